// ----- hw/rtl/graph_depth_first_traversal_macros.svh -----
// Assertion macros shared by the graph traversal RTL.
`ifndef GRAPH_DEPTH_FIRST_TRAVERSAL_MACROS_SVH
`define GRAPH_DEPTH_FIRST_TRAVERSAL_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define GDFT_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Plain condition checked on every clock edge outside reset.
`define GDFT_ALWAYS(label, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);

`endif

// ----- hw/rtl/gdft_pkg.sv -----
// Types, codes and defaults for the graph traversal block.
package gdft_pkg;

	localparam int DEF_MAX_NODES  = 64;
	localparam int DEF_MAX_DEGREE = 16;
	localparam int NODE_W         = 6;
	localparam int NCOUNT_W       = 7;

	typedef enum logic [1:0] {
		K_ADD    = 2'd0,
		K_REMOVE = 2'd1,
		K_DFS    = 2'd2,
		K_NONE   = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_FULL      = 2'd1,
		ST_NOT_FOUND = 2'd2,
		ST_RANGE     = 2'd3
	} status_t;

	localparam logic REG_NODE_COUNT = 1'b0;

	typedef struct packed {
		logic [1:0]        kind;
		logic [NODE_W-1:0] node_a;
		logic [NODE_W-1:0] node_b;
	} cmd_t;

	typedef struct packed {
		logic [NODE_W-1:0] node;
		logic              last;
		logic [1:0]        status;
	} rsp_t;

	typedef enum logic [4:0] {
		S_IDLE,
		S_RESULT,
		S_A_DA,
		S_A_DB,
		S_A_CHK,
		S_A_WB,
		S_D_DEG,
		S_D_LEN,
		S_D_SRD,
		S_D_SCK,
		S_D_HRD,
		S_D_HWR,
		S_T_POP,
		S_T_POPD,
		S_T_DEG,
		S_T_NRD,
		S_T_NCK,
		S_T_EMIT
	} state_t;

endpackage

// ----- hw/rtl/graph_depth_first_traversal.sv -----
// Undirected graph store with edge add/remove and depth-first traversal.
// Each beat on cmd is one operation; the block stalls cmd until all of its result beats
// are loaded into the rsp register. An add reads both degrees, checks for a full list,
// and writes both list entries unless the edge is dropped. A remove scans the list for
// the entry, shifts the tail down over it, and repeats for the mirror list. A traversal
// pops a node, reads its degree, reads each list entry and pushes unvisited neighbours,
// then emits the node, waiting while rsp_stall holds a waiting beat. No clearing pass is
// needed after reset.
module graph_depth_first_traversal #(
	parameter int MAX_NODES  = gdft_pkg::DEF_MAX_NODES,
	parameter int MAX_DEGREE = gdft_pkg::DEF_MAX_DEGREE
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          psel,
	input  logic          penable,
	input  logic          pwrite,
	input  logic [2:0]    paddr,
	input  logic [31:0]   pwdata,
	output logic [31:0]   prdata,
	output logic          pready,
	input  logic          cmd_valid,
	output logic          cmd_stall,
	input  gdft_pkg::cmd_t cmd,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output gdft_pkg::rsp_t rsp
);
	import gdft_pkg::*;

	localparam int NIW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
	localparam int DW  = $clog2(MAX_DEGREE + 1);
	localparam int AW  = (MAX_NODES * MAX_DEGREE > 1) ? $clog2(MAX_NODES * MAX_DEGREE) : 1;
	localparam int SPW = $clog2(MAX_NODES + 1);

	function automatic logic [AW-1:0] ent_addr(input logic [NIW-1:0] n, input logic [DW-1:0] i);
		return AW'(n) * AW'(MAX_DEGREE) + AW'(i);
	endfunction

	// config register
	logic [NCOUNT_W-1:0] node_count_q;
	logic                cfg_wr;
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_count_q <= NCOUNT_W'(MAX_NODES);
		end else if (cfg_wr && paddr[2] == REG_NODE_COUNT) begin
			node_count_q <= pwdata[NCOUNT_W-1:0];
		end
	end
	assign prdata = (paddr[2] == REG_NODE_COUNT) ? {{(32-NCOUNT_W){1'b0}}, node_count_q} : '0;

	logic [NCOUNT_W-1:0] lim;
	assign lim = (node_count_q > NCOUNT_W'(MAX_NODES)) ? NCOUNT_W'(MAX_NODES) : node_count_q;

	// sequencer registers
	state_t              state_q, state_d;
	logic [NODE_W-1:0]   a_q, b_q, dn_q, dv_q, x_q;
	logic                pass_q;
	logic [DW-1:0]       len_q, i_q, dega_q, degb_q;
	logic [SPW-1:0]      sp_q;
	status_t             stat_q;
	logic [MAX_NODES-1:0] visited_q;
	rsp_t                rsp_q;
	logic                rsp_valid_q;

	// memory ports
	logic [NODE_W-1:0] st_mem [MAX_NODES*MAX_DEGREE];
	logic [AW-1:0]     st_raddr, st_waddr;
	logic [NODE_W-1:0] st_wdata, st_rd_q;
	logic              st_we;

	logic [DW-1:0]     deg_mem [MAX_NODES];
	logic [MAX_NODES-1:0] deg_vld_q;
	logic [NIW-1:0]    deg_raddr, deg_waddr;
	logic [DW-1:0]     deg_wdata, deg_rd_q, deg_eff;
	logic              deg_we, deg_rv_q;

	logic [NODE_W-1:0] stk_mem [MAX_NODES];
	logic [NIW-1:0]    stk_raddr, stk_waddr;
	logic [NODE_W-1:0] stk_wdata, stk_rd_q;
	logic              stk_we;

	always_ff @(posedge clk) begin
		if (st_we) begin
			st_mem[st_waddr] <= st_wdata;
		end
		st_rd_q <= st_mem[st_raddr];
	end

	always_ff @(posedge clk) begin
		if (deg_we) begin
			deg_mem[deg_waddr] <= deg_wdata;
		end
		deg_rd_q <= deg_mem[deg_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			deg_vld_q <= '0;
			deg_rv_q  <= 1'b0;
		end else begin
			if (deg_we) begin
				deg_vld_q[deg_waddr] <= 1'b1;
			end
			deg_rv_q <= deg_vld_q[deg_raddr];
		end
	end
	assign deg_eff = deg_rv_q ? deg_rd_q : '0;

	always_ff @(posedge clk) begin
		if (stk_we) begin
			stk_mem[stk_waddr] <= stk_wdata;
		end
		stk_rd_q <= stk_mem[stk_raddr];
	end

	// combinational helpers
	logic cmd_acc, out_free, range_bad, full, nb_ok, hit_end, shift_end;
	logic [SPW-1:0] sp_dec;
	logic [DW:0]    dega_p2;
	logic [DW-1:0]  i_inc;
	assign cmd_acc  = cmd_valid && !cmd_stall;
	assign out_free = !rsp_valid_q || !rsp_stall;
	assign sp_dec   = sp_q - SPW'(1);
	assign i_inc    = i_q + DW'(1);
	assign range_bad = ({1'b0, cmd.node_a} >= lim) ||
		((cmd.kind != K_DFS) && ({1'b0, cmd.node_b} >= lim));
	assign dega_p2  = {1'b0, dega_q} + (DW+1)'(2);
	assign full = (a_q == b_q) ? (dega_p2 > (DW+1)'(MAX_DEGREE)) :
		((dega_q >= DW'(MAX_DEGREE)) || (deg_eff >= DW'(MAX_DEGREE)));
	assign nb_ok = ({1'b0, st_rd_q} < NCOUNT_W'(MAX_NODES)) && !visited_q[st_rd_q[NIW-1:0]];
	assign hit_end   = (i_q == len_q);
	assign shift_end = ({1'b0, i_q} + (DW+1)'(1)) >= {1'b0, len_q};
	assign cmd_stall = (state_q != S_IDLE);

	// next state and memory controls
	always_comb begin
		state_d   = state_q;
		st_raddr  = ent_addr(dn_q[NIW-1:0], i_q);
		st_waddr  = ent_addr(a_q[NIW-1:0], dega_q);
		st_wdata  = b_q;
		st_we     = 1'b0;
		deg_raddr = a_q[NIW-1:0];
		deg_waddr = a_q[NIW-1:0];
		deg_wdata = dega_q + DW'(1);
		deg_we    = 1'b0;
		stk_raddr = sp_dec[NIW-1:0];
		stk_waddr = sp_q[NIW-1:0];
		stk_wdata = st_rd_q;
		stk_we    = 1'b0;
		case (state_q)
			S_IDLE: begin
				stk_waddr = '0;
				stk_wdata = cmd.node_a;
				if (cmd_acc) begin
					if (cmd.kind == K_NONE || range_bad) begin
						state_d = S_RESULT;
					end else if (cmd.kind == K_ADD) begin
						state_d = S_A_DA;
					end else if (cmd.kind == K_REMOVE) begin
						state_d = S_D_DEG;
					end else begin
						stk_we  = 1'b1;
						state_d = S_T_POP;
					end
				end
			end
			S_RESULT: begin
				if (out_free) state_d = S_IDLE;
			end
			S_A_DA: state_d = S_A_DB;
			S_A_DB: begin
				deg_raddr = b_q[NIW-1:0];
				state_d   = S_A_CHK;
			end
			S_A_CHK: begin
				if (full) begin
					state_d = S_RESULT;
				end else begin
					st_we   = 1'b1;
					deg_we  = 1'b1;
					state_d = S_A_WB;
				end
			end
			S_A_WB: begin
				st_waddr  = ent_addr(b_q[NIW-1:0], degb_q);
				st_wdata  = a_q;
				st_we     = 1'b1;
				deg_waddr = b_q[NIW-1:0];
				deg_wdata = degb_q + DW'(1);
				deg_we    = 1'b1;
				state_d   = S_RESULT;
			end
			S_D_DEG: begin
				deg_raddr = dn_q[NIW-1:0];
				state_d   = S_D_LEN;
			end
			S_D_LEN: state_d = S_D_SRD;
			S_D_SRD: begin
				state_d = hit_end ? S_RESULT : S_D_SCK;
			end
			S_D_SCK: begin
				state_d = (st_rd_q == dv_q) ? S_D_HRD : S_D_SRD;
			end
			S_D_HRD: begin
				st_raddr = ent_addr(dn_q[NIW-1:0], i_inc);
				if (shift_end) begin
					deg_waddr = dn_q[NIW-1:0];
					deg_wdata = len_q - DW'(1);
					deg_we    = 1'b1;
					state_d   = pass_q ? S_RESULT : S_D_DEG;
				end else begin
					state_d = S_D_HWR;
				end
			end
			S_D_HWR: begin
				st_waddr = ent_addr(dn_q[NIW-1:0], i_q);
				st_wdata = st_rd_q;
				st_we    = 1'b1;
				state_d  = S_D_HRD;
			end
			S_T_POP: state_d = S_T_POPD;
			S_T_POPD: begin
				deg_raddr = stk_rd_q[NIW-1:0];
				state_d   = S_T_DEG;
			end
			S_T_DEG: state_d = S_T_NRD;
			S_T_NRD: begin
				st_raddr = ent_addr(x_q[NIW-1:0], i_q);
				state_d  = hit_end ? S_T_EMIT : S_T_NCK;
			end
			S_T_NCK: begin
				stk_we  = nb_ok;
				state_d = S_T_NRD;
			end
			S_T_EMIT: begin
				if (out_free) state_d = (sp_q == '0) ? S_IDLE : S_T_POP;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// datapath registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sp_q      <= '0;
			visited_q <= '0;
			pass_q    <= 1'b0;
			stat_q    <= ST_OK;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (cmd_acc) begin
						pass_q <= 1'b0;
						stat_q <= (cmd.kind != K_NONE && range_bad) ? ST_RANGE : ST_OK;
						if (cmd.kind == K_DFS && !range_bad) begin
							// clear the map, leaving only the start node marked
							visited_q <= MAX_NODES'(1) << cmd.node_a[NIW-1:0];
							sp_q <= SPW'(1);
						end
					end
				end
				S_A_CHK: stat_q <= full ? ST_FULL : ST_OK;
				S_D_SRD: begin
					if (hit_end) stat_q <= pass_q ? ST_OK : ST_NOT_FOUND;
				end
				S_D_HRD: begin
					if (shift_end) pass_q <= 1'b1;
				end
				S_T_POP: sp_q <= sp_dec;
				S_T_NCK: begin
					if (nb_ok) begin
						visited_q[st_rd_q[NIW-1:0]] <= 1'b1;
						sp_q <= sp_q + SPW'(1);
					end
				end
				default: ;
			endcase
		end
	end

	// payload registers, no reset needed
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (cmd_acc) begin
					a_q    <= cmd.node_a;
					b_q    <= cmd.node_b;
					dn_q   <= cmd.node_a;
					dv_q   <= cmd.node_b;
				end
			end
			S_A_DB: dega_q <= deg_eff;
			S_A_CHK: degb_q <= (a_q == b_q) ? dega_q + DW'(1) : deg_eff;
			S_D_LEN: begin
				len_q <= deg_eff;
				i_q   <= '0;
			end
			S_D_SCK: begin
				if (st_rd_q != dv_q) i_q <= i_inc;
			end
			S_D_HRD: begin
				if (shift_end) begin
					dn_q <= b_q;
					dv_q <= a_q;
				end
			end
			S_D_HWR: i_q <= i_inc;
			S_T_POPD: x_q <= stk_rd_q;
			S_T_DEG: begin
				len_q <= deg_eff;
				i_q   <= '0;
			end
			S_T_NCK: i_q <= i_inc;
			default: ;
		endcase
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (out_free) begin
			rsp_valid_q <= (state_q == S_RESULT) || (state_q == S_T_EMIT);
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			if (state_q == S_RESULT) begin
				rsp_q.node   <= '0;
				rsp_q.last   <= 1'b1;
				rsp_q.status <= stat_q;
			end else if (state_q == S_T_EMIT) begin
				rsp_q.node   <= x_q;
				rsp_q.last   <= (sp_q == '0);
				rsp_q.status <= ST_OK;
			end
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

`include "graph_depth_first_traversal_macros.svh"

	`GDFT_ASSERT(a_rsp_hold, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp), "rsp changed while stalled")
	`GDFT_ALWAYS(a_sp_bound, sp_q <= SPW'(MAX_NODES), "stack pointer past depth")
	`GDFT_ASSERT(a_busy_after_cmd, cmd_valid && !cmd_stall |=> cmd_stall, "accepted command left no work")
	`GDFT_ASSERT(a_pop_nonempty, state_q == S_T_POP |-> sp_q != '0, "pop from empty stack")

endmodule
